// File: design/sample_to_color_map_top_macros.svh
// Assertion macros shared by the checker of the color map block.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef SAMPLE_TO_COLOR_MAP_TOP_MACROS_SVH
`define SAMPLE_TO_COLOR_MAP_TOP_MACROS_SVH

// a holds at an edge, so c holds at the same edge
`define STM_ASSERT_IMP(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("color map check failed");

// a holds at an edge, so c holds later, after the delay given by n
`define STM_ASSERT_DLY(label, a, n, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> ##n (c)) \
		else $error("color map check failed");

`endif

// File: design/stm_pkg.sv
// Shared types and constants of the sample to color map block.
// No dependencies.
package stm_pkg;

	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 8;
	localparam int FOLD_BITS     = 6;
	localparam int HUE_BITS      = 11;

	localparam logic [CFG_IDX_BITS-1:0] CFG_COLOR_MODE   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE_FACTOR = 2'd1;

	localparam logic [7:0] SCALE_RESET = 8'd1;

	// low bits of the scaled sample, the dark flag and the mode travel with each beat
	typedef struct packed {
		logic       mode;
		logic       dark;
		logic [8:0] low9;
	} stm_side_t;

endpackage

// File: design/sample_to_color_map_top.sv
// Top level of the sample to color map block: config registers and pipeline.
// Depends on stm_pkg, stm_scale, stm_wheel and stm_dim.
//
//   channel   signals                                  handshake
//   input     start, busy, sample                      start & !busy
//   result    done, red, green, blue                   done, one cycle
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid & cfg_ready
//
// A sample can be taken every cycle; busy stays low.
// Each result passes through the registered stages in order: multiply,
// digit fold, mod-1536 assembly, wheel segments and dimming multiply.
// Reset clears the stage valid bits and sets grey mode with scale 1.
// No stage ever stalls; the result receiver takes each beat as it comes.
module sample_to_color_map_top #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [SAMPLE_BITS-1:0]            sample,
	output logic                              done,
	output logic [7:0]                        red,
	output logic [7:0]                        green,
	output logic [7:0]                        blue,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [stm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [stm_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import stm_pkg::*;

	logic               mode_q;
	logic [7:0]         scale_q;
	logic               valid_s2, valid_s4;
	logic [FOLD_BITS-1:0] sum_s2;
	stm_side_t          side_s2, side_s4;
	logic [7:0]         red_s4, green_s4, blue_s4;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			scale_q <= SCALE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_COLOR_MODE) begin
				mode_q <= cfg_data[0];
			end else if (cfg_index == CFG_SCALE_FACTOR) begin
				scale_q <= cfg_data[7:0];
			end
		end
	end

	stm_scale #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.sample   (sample),
		.mode     (mode_q),
		.scale    (scale_q),
		.valid_s2 (valid_s2),
		.sum_s2   (sum_s2),
		.side_s2  (side_s2)
	);

	stm_wheel u_wheel (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.sum_s2   (sum_s2),
		.side_s2  (side_s2),
		.valid_s4 (valid_s4),
		.red_s4   (red_s4),
		.green_s4 (green_s4),
		.blue_s4  (blue_s4),
		.side_s4  (side_s4)
	);

	stm_dim u_dim (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s4 (valid_s4),
		.red_s4   (red_s4),
		.green_s4 (green_s4),
		.blue_s4  (blue_s4),
		.side_s4  (side_s4),
		.done     (done),
		.red      (red),
		.green    (green),
		.blue     (blue)
	);

endmodule

// File: design/stm_scale.sv
// Scale and residue stages: multiply sample by the scale factor, then fold
// the bits of weight 512 and up into a base-4 digit sum for the mod-3 step. Uses stm_pkg.
module stm_scale #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [SAMPLE_BITS-1:0]        sample,
	input  logic                          mode,
	input  logic [7:0]                    scale,
	output logic                          valid_s2,
	output logic [stm_pkg::FOLD_BITS-1:0] sum_s2,
	output stm_pkg::stm_side_t            side_s2
);
	import stm_pkg::*;

	localparam int PW  = SAMPLE_BITS + 8;
	localparam int QW  = PW - 9;
	localparam int ND  = (QW + 1) / 2;
	localparam int QPW = 2 * ND;
	localparam int SW  = $clog2(3 * ND + 1);

	logic          valid_s1;
	logic          mode_s1;
	logic [PW-1:0] p_s1;
	logic [QPW-1:0] qpad;
	logic [SW-1:0]  dsum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_s1    <= PW'(sample) * PW'(scale);
		mode_s1 <= mode;
	end

	assign qpad = QPW'(p_s1[PW-1:9]);

	// 4 is 1 mod 3, so the base-4 digit sum keeps the residue
	always_comb begin
		dsum = '0;
		for (int i = 0; i < ND; i++) begin
			dsum = dsum + SW'(qpad[2*i +: 2]);
		end
	end

	always_ff @(posedge clk) begin
		sum_s2       <= FOLD_BITS'(dsum);
		side_s2.mode <= mode_s1;
		side_s2.dark <= (p_s1[PW-1:8] == '0);
		side_s2.low9 <= p_s1[8:0];
	end

endmodule

// File: design/stm_wheel.sv
// Hue wheel stages: finish p mod 1536, then evaluate the six-segment wheel.
// Uses stm_pkg.
module stm_wheel (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s2,
	input  logic [stm_pkg::FOLD_BITS-1:0] sum_s2,
	input  stm_pkg::stm_side_t            side_s2,
	output logic                          valid_s4,
	output logic [7:0]                    red_s4,
	output logic [7:0]                    green_s4,
	output logic [7:0]                    blue_s4,
	output stm_pkg::stm_side_t            side_s4
);
	import stm_pkg::*;

	logic                valid_s3;
	logic [HUE_BITS-1:0] h_s3;
	stm_side_t           side_s3;
	logic [3:0]          fold;
	logic [1:0]          res3;
	logic [HUE_BITS-1:0] rc, gc, bc;

	assign fold = 4'(sum_s2[1:0]) + 4'(sum_s2[3:2]) + 4'(sum_s2[5:4]);

	always_comb begin
		if (fold >= 4'd6) begin
			res3 = 2'(fold - 4'd6);
		end else if (fold >= 4'd3) begin
			res3 = 2'(fold - 4'd3);
		end else begin
			res3 = fold[1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		h_s3    <= {res3, side_s2.low9};
		side_s3 <= side_s2;
	end

	always_comb begin
		if (h_s3 <= 11'd256 || h_s3 >= 11'd1280) begin
			rc = 11'd255;
		end else if (h_s3 <= 11'd512) begin
			rc = 11'd512 - h_s3;
		end else if (h_s3 < 11'd1024) begin
			rc = '0;
		end else begin
			rc = h_s3 - 11'd1024;
		end

		if (h_s3 < 11'd256) begin
			gc = h_s3;
		end else if (h_s3 <= 11'd768) begin
			gc = 11'd255;
		end else if (h_s3 <= 11'd1024) begin
			gc = 11'd1024 - h_s3;
		end else begin
			gc = '0;
		end

		if (h_s3 < 11'd512) begin
			bc = '0;
		end else if (h_s3 < 11'd768) begin
			bc = h_s3 - 11'd512;
		end else if (h_s3 <= 11'd1280) begin
			bc = 11'd255;
		end else begin
			bc = 11'd1536 - h_s3;
		end
	end

	always_ff @(posedge clk) begin
		red_s4   <= rc[7:0];
		green_s4 <= gc[7:0];
		blue_s4  <= bc[7:0];
		side_s4  <= side_s3;
	end

endmodule

// File: design/stm_dim.sv
// Output stage: dim the wheel color for small products, or emit the grey
// triangle value. Uses stm_pkg.
module stm_dim (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s4,
	input  logic [7:0]         red_s4,
	input  logic [7:0]         green_s4,
	input  logic [7:0]         blue_s4,
	input  stm_pkg::stm_side_t side_s4,
	output logic               done,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue
);
	import stm_pkg::*;

	logic [7:0]  grey;
	logic [15:0] rp, gp, bp;

	// 511 - t for t in 256..511 is the complement of the low byte
	assign grey = side_s4.low9[8] ? ~side_s4.low9[7:0] : side_s4.low9[7:0];

	assign rp = 16'(red_s4)   * 16'(side_s4.low9[7:0]);
	assign gp = 16'(green_s4) * 16'(side_s4.low9[7:0]);
	assign bp = 16'(blue_s4)  * 16'(side_s4.low9[7:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (!side_s4.mode) begin
			red   <= grey;
			green <= grey;
			blue  <= grey;
		end else if (side_s4.dark) begin
			red   <= rp[15:8];
			green <= gp[15:8];
			blue  <= bp[15:8];
		end else begin
			red   <= red_s4;
			green <= green_s4;
			blue  <= blue_s4;
		end
	end

endmodule

// File: design/stm_checker.sv
// Port-level checks of the color map block and their bind to the top level.
// Depends on stm_pkg and sample_to_color_map_top_macros.svh.
`include "sample_to_color_map_top_macros.svh"

module stm_checker #(
	parameter int SAMPLE_BITS = 16
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic [SAMPLE_BITS-1:0]            sample,
	input logic                              done,
	input logic [7:0]                        red,
	input logic [7:0]                        green,
	input logic [7:0]                        blue,
	input logic                              cfg_valid,
	input logic                              cfg_ready,
	input logic [stm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input logic [stm_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import stm_pkg::*;

	// every taken sample yields a done beat once it has passed the pipeline
	`STM_ASSERT_DLY(a_latency, start && !busy, 5, done)
	// no beat without a sample taken for it at the pipeline input
	`STM_ASSERT_IMP(a_no_spurious, done, $past(start && !busy, 5))
	// a zero sample is black in either mode
	`STM_ASSERT_DLY(a_zero_black, start && !busy && sample == '0, 5,
		red == 8'd0 && green == 8'd0 && blue == 8'd0)
	// config writes are never held off
	`STM_ASSERT_IMP(a_cfg_open, cfg_valid, cfg_ready)

endmodule

bind sample_to_color_map_top stm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_stm_checker (.*);

// File: tb/testbench.sv
// Self-checking bench for sample_to_color_map_top: a driver and a pixel monitor,
// with the grey triangle map and the dimmed hue wheel computed in the bench itself.
// Depends on stm_pkg and the sample_to_color_map_top RTL.
module testbench;
	import stm_pkg::*;

	localparam int SAMPLE_W      = 16;
	localparam int SETTLE_CYCLES = 10;
	localparam int BLOCK_ITEMS   = 50;

	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_3 = 2'd3;

	typedef enum logic [1:0] {WK_SAMPLE, WK_WRITE, WK_SETTLE} work_kind_t;

	typedef struct {
		work_kind_t               kind;
		logic [SAMPLE_W-1:0]      value;
		logic [CFG_IDX_BITS-1:0]  index;
		logic [CFG_DATA_BITS-1:0] data;
		int unsigned              idle_pct;
	} work_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} pixel_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     start     = 1'b0;
	logic [SAMPLE_W-1:0]      sample    = '0;
	logic                     cfg_valid = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
	logic                     busy;
	logic                     done;
	logic                     cfg_ready;
	logic [7:0]               red;
	logic [7:0]               green;
	logic [7:0]               blue;

	work_t       work_list[$];
	pixel_t      pixels_due[$];
	int unsigned fault_count = 0;

	logic        mode_now;
	logic [7:0]  scale_now;
	int unsigned settle_count;
	logic        next_start;
	logic        next_cfg;
	work_t       head;
	pixel_t      want;

	sample_to_color_map_top #(.SAMPLE_BITS(SAMPLE_W)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.sample    (sample),
		.done      (done),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#2000000;
		$display("testbench: errors");
		$finish;
	end

	function automatic pixel_t map_to_pixel(logic [SAMPLE_W-1:0] s, logic mode,
			logic [7:0] scale);
		int unsigned prod;
		int unsigned h;
		int unsigned t;
		int unsigned r;
		int unsigned g;
		int unsigned b;
		pixel_t      px;
		prod = s * scale;
		if (mode) begin
			h = prod % 1536;
			if (h <= 256 || h >= 1280) r = 255;
			else if (h <= 512) r = 512 - h;
			else if (h < 1024) r = 0;
			else r = h - 1024;
			if (h < 256) g = h;
			else if (h <= 768) g = 255;
			else if (h <= 1024) g = 1024 - h;
			else g = 0;
			if (h < 512) b = 0;
			else if (h < 768) b = h - 512;
			else if (h <= 1280) b = 255;
			else b = 1536 - h;
			// dim the dark end of the wheel
			if (prod < 256) begin
				r = (r * prod) >> 8;
				g = (g * prod) >> 8;
				b = (b * prod) >> 8;
			end
		end else begin
			t = prod % 512;
			r = (t < 256) ? t : 511 - t;
			g = r;
			b = r;
		end
		px.r = r[7:0];
		px.g = g[7:0];
		px.b = b[7:0];
		return px;
	endfunction

	function automatic void add_sample(logic [SAMPLE_W-1:0] value, int unsigned idle_pct);
		work_t w;
		w.kind     = WK_SAMPLE;
		w.value    = value;
		w.index    = '0;
		w.data     = '0;
		w.idle_pct = idle_pct;
		work_list.push_back(w);
	endfunction

	function automatic void add_settle();
		work_t w;
		w.kind     = WK_SETTLE;
		w.value    = '0;
		w.index    = '0;
		w.data     = '0;
		w.idle_pct = 0;
		work_list.push_back(w);
	endfunction

	// register writes only go out once the pipeline has drained
	function automatic void add_write(logic [CFG_IDX_BITS-1:0] index,
			logic [CFG_DATA_BITS-1:0] data);
		work_t w;
		add_settle();
		w.kind     = WK_WRITE;
		w.value    = '0;
		w.index    = index;
		w.data     = data;
		w.idle_pct = 0;
		work_list.push_back(w);
	endfunction

	// driver: issue sample and register beats, predict each accepted sample
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start        <= 1'b0;
			cfg_valid    <= 1'b0;
			mode_now     = 1'b0;
			scale_now    = SCALE_RESET;
			settle_count = 0;
		end else begin
			next_start = start && busy;
			next_cfg   = cfg_valid && !cfg_ready;
			if (start && !busy)
				pixels_due.push_back(map_to_pixel(sample, mode_now, scale_now));
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_COLOR_MODE)
					mode_now = cfg_data[0];
				else if (cfg_index == CFG_SCALE_FACTOR)
					scale_now = cfg_data;
			end
			if (!next_start && !next_cfg && work_list.size() != 0) begin
				head = work_list[0];
				case (head.kind)
					WK_SAMPLE: begin
						if ($urandom_range(99) >= head.idle_pct) begin
							next_start = 1'b1;
							sample <= head.value;
							void'(work_list.pop_front());
						end
					end
					WK_WRITE: begin
						next_cfg = 1'b1;
						cfg_index <= head.index;
						cfg_data  <= head.data;
						void'(work_list.pop_front());
					end
					WK_SETTLE: begin
						if (pixels_due.size() == 0) begin
							settle_count++;
							if (settle_count >= SETTLE_CYCLES) begin
								settle_count = 0;
								void'(work_list.pop_front());
							end
						end else begin
							settle_count = 0;
						end
					end
					default: void'(work_list.pop_front());
				endcase
			end
			start     <= next_start;
			cfg_valid <= next_cfg;
		end
	end

	// monitor: every done beat is checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pixels_due.size() == 0) begin
				$error("unexpected pixel r=%0d g=%0d b=%0d", red, green, blue);
				fault_count++;
			end else begin
				want = pixels_due.pop_front();
				if (red !== want.r) begin
					$error("red: expected %0d, got %0d", want.r, red);
					fault_count++;
				end
				if (green !== want.g) begin
					$error("green: expected %0d, got %0d", want.g, green);
					fault_count++;
				end
				if (blue !== want.b) begin
					$error("blue: expected %0d, got %0d", want.b, blue);
					fault_count++;
				end
			end
		end
	end

	initial begin
		int unsigned         idle_by_phase[3];
		logic [SAMPLE_W-1:0] value;
		logic [7:0]          word;
		idle_by_phase[0] = 11;
		idle_by_phase[1] = 79;
		idle_by_phase[2] = 0;

		// grey map at reset settings: both ends of the triangle and the fold
		add_sample(16'd0, 0);
		add_sample(16'd255, 0);
		add_sample(16'd256, 0);
		add_sample(16'd511, 0);
		add_sample(16'd512, 0);
		add_sample(16'hFFFF, 0);

		// hue wheel breakpoints at scale 1, the low ones dimmed
		add_write(CFG_COLOR_MODE, 8'h01);
		add_sample(16'd0, 0);
		add_sample(16'd128, 0);
		add_sample(16'd255, 0);
		add_sample(16'd256, 0);
		add_sample(16'd257, 0);
		add_sample(16'd512, 0);
		add_sample(16'd768, 0);
		add_sample(16'd1024, 0);
		add_sample(16'd1280, 0);
		add_sample(16'd1281, 0);
		add_sample(16'd1535, 0);
		add_sample(16'd1536, 0);

		add_write(CFG_SCALE_FACTOR, 8'hFF);
		add_sample(16'd1, 0);
		add_sample(16'hFFFF, 0);

		// zero scale gives black in both modes
		add_write(CFG_SCALE_FACTOR, 8'h00);
		add_sample(16'h1234, 0);
		// upper data bits dropped: this selects grey
		add_write(CFG_COLOR_MODE, 8'hFE);
		add_sample(16'h1234, 0);

		// unused indexes must not touch the scale
		add_write(CFG_SPARE_2, 8'h55);
		add_write(CFG_SPARE_3, 8'hAA);
		add_sample(16'h00FF, 0);

		for (int ph = 0; ph < 3; ph++) begin
			for (int blk = 0; blk < 8; blk++) begin
				case ($urandom_range(5))
					0: word = 8'h00;
					1: word = 8'h01;
					2: word = 8'hFF;
					default: word = 8'($urandom);
				endcase
				add_write(CFG_SCALE_FACTOR, word);
				word = 8'($urandom);
				word[0] = blk[0];
				add_write(CFG_COLOR_MODE, word);
				if ($urandom_range(3) == 0)
					add_write($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3,
						CFG_DATA_BITS'($urandom));
				for (int n = 0; n < BLOCK_ITEMS; n++) begin
					case ($urandom_range(9))
						0, 1: value = SAMPLE_W'($urandom_range(1535));
						2: begin
							case ($urandom_range(3))
								0: value = 16'h0000;
								1: value = 16'h0001;
								2: value = 16'h8000;
								default: value = 16'hFFFF;
							endcase
						end
						default: value = SAMPLE_W'($urandom);
					endcase
					// hold off until the pipeline is empty now and then
					if (n == BLOCK_ITEMS / 2 && blk % 3 == 0)
						add_settle();
					add_sample(value, idle_by_phase[ph]);
				end
			end
		end

		while (work_list.size() != 0 || start || cfg_valid || pixels_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
